/* sv/i2cm_pkg.sv */
// Shared types and constants for the I2C master register access unit.
// No dependencies; every other file imports this package.
package i2cm_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 16;

	// Request kinds carried in the input tuser.
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_BEGIN = 2'd1;
	localparam logic [1:0] REQ_WBYTE = 2'd2;

	localparam logic [7:0] READ_FLAG = 8'h01;
	localparam logic [2:0] BIT_MSB   = 3'd7;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_STA,
		PH_STB,
		PH_STC,
		PH_WSET,
		PH_WHI,
		PH_WLO,
		PH_AHI,
		PH_ALO,
		PH_RHI,
		PH_RLO,
		PH_MSET,
		PH_MHI,
		PH_MLO,
		PH_SPA,
		PH_SPB,
		PH_SPC,
		PH_WAIT
	} phase_t;

	// Which byte of the transaction is on the bus.
	typedef enum logic [1:0] {
		STG_DEV,
		STG_REG,
		STG_RDEV,
		STG_DATA
	} stage_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic               is_read;
		logic [7:0]         slave_addr;
		logic [7:0]         reg_index;
		logic [COUNT_W-1:0] byte_count;
		logic [7:0]         write_data;
		logic               sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic [7:0] read_data;
		logic       read_valid;
		logic       need_byte;
		logic       busy_res;
		logic       done_res;
		logic       status;
	} res_t;

endpackage

/* sv/i2cm_in_reg.sv */
// Input register stage of the I2C master register access unit.
// Depends on i2cm_pkg for the item type.
module i2cm_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	output logic           s_ready,
	input  i2cm_pkg::item_t item,
	input  logic           take,
	output logic           valid_s1,
	output i2cm_pkg::item_t item_s1
);
	import i2cm_pkg::*;

	logic accept;

	// The stage frees itself in the same cycle its beat moves on.
	assign s_ready = !valid_s1 || take;
	assign accept  = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

/* sv/i2cm_core.sv */
// Bus phase sequencer of the I2C master: transaction state, line levels and
// the per-beat result. Depends on i2cm_pkg.
module i2cm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2cm_pkg::TICK_W-1:0]   cfg_data,
	input  logic                          step,
	input  i2cm_pkg::item_t               item,
	output i2cm_pkg::res_t                res
);
	import i2cm_pkg::*;

	phase_t             phase_q, phase_n;
	stage_t             stage_q, stage_n;
	logic [2:0]         bit_q, bit_n;
	logic [COUNT_W-1:0] bytes_q, bytes_n;
	logic [7:0]         shift_q, shift_n;
	logic [TICK_W-1:0]  tick_q, tick_n;
	logic               rmode_q, rmode_n;
	logic [7:0]         dev_q, dev_n;
	logic [7:0]         reg_q, reg_n;
	logic [7:0]         held_q, held_n;
	logic               held_vld_q, held_vld_n;
	logic               nack_q, nack_n;
	logic               scl_q, scl_n;
	logic               sda_q, sda_n;
	logic [TICK_W-1:0]  ticks_q;
	logic [TICK_W-1:0]  ticks_eff;
	logic               is_tick;
	logic               fire;
	logic               rvalid;
	logic               done;
	logic               rel;

	assign ticks_eff = (ticks_q == '0) ? TICK_W'(1) : ticks_q;
	assign is_tick   = (item.req_type == REQ_TICK) && (phase_q != PH_IDLE);
	// A phase ends on this beat: the tick that exhausts the step count.
	assign fire      = is_tick && (phase_q != PH_WAIT) && (tick_q <= TICK_W'(1));

	// Next state.
	always_comb begin
		logic   go_en;
		phase_t go_to;
		logic   nwd;

		go_en      = 1'b0;
		go_to      = phase_q;
		nwd        = 1'b0;
		phase_n    = phase_q;
		stage_n    = stage_q;
		bit_n      = bit_q;
		bytes_n    = bytes_q;
		shift_n    = shift_q;
		tick_n     = tick_q;
		rmode_n    = rmode_q;
		dev_n      = dev_q;
		reg_n      = reg_q;
		held_n     = held_q;
		held_vld_n = held_vld_q;
		nack_n     = nack_q;
		scl_n      = scl_q;
		sda_n      = sda_q;

		case (item.req_type)
			REQ_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					rmode_n    = item.is_read;
					dev_n      = item.slave_addr;
					reg_n      = item.reg_index;
					bytes_n    = item.byte_count;
					nack_n     = 1'b0;
					held_vld_n = 1'b0;
					stage_n    = STG_DEV;
					bit_n      = '0;
					shift_n    = '0;
					go_en      = 1'b1;
					go_to      = PH_STA;
				end
			end
			REQ_WBYTE: begin
				if (phase_q != PH_IDLE && !rmode_q) begin
					held_n     = item.write_data;
					held_vld_n = 1'b1;
				end
			end
			REQ_TICK: begin
				if (is_tick) begin
					if (phase_q == PH_WAIT) begin
						nwd = held_vld_q;
					end else if (!fire) begin
						tick_n = tick_q - TICK_W'(1);
					end else begin
						case (phase_q)
							PH_STA: begin go_en = 1'b1; go_to = PH_STB; end
							PH_STB: begin go_en = 1'b1; go_to = PH_STC; end
							PH_STC: begin
								shift_n = (stage_q == STG_RDEV) ? (dev_q | READ_FLAG) : dev_q;
								bit_n   = BIT_MSB;
								go_en   = 1'b1;
								go_to   = PH_WSET;
							end
							PH_WSET: begin go_en = 1'b1; go_to = PH_WHI; end
							PH_WHI:  begin go_en = 1'b1; go_to = PH_WLO; end
							PH_WLO: begin
								go_en = 1'b1;
								if (bit_q == '0) begin
									go_to = PH_AHI;
								end else begin
									bit_n = bit_q - 3'd1;
									go_to = PH_WSET;
								end
							end
							PH_AHI: begin
								if (item.sda_in) begin
									nack_n = 1'b1;
								end
								go_en = 1'b1;
								go_to = PH_ALO;
							end
							PH_ALO: begin
								// A NACK during a read aborts straight into the stop.
								if (rmode_q && nack_q) begin
									go_en = 1'b1;
									go_to = PH_SPA;
								end else begin
									case (stage_q)
										STG_DEV: begin
											stage_n = STG_REG;
											shift_n = reg_q;
											bit_n   = BIT_MSB;
											go_en   = 1'b1;
											go_to   = PH_WSET;
										end
										STG_REG: begin
											if (rmode_q) begin
												stage_n = STG_RDEV;
												go_en   = 1'b1;
												go_to   = PH_STA;
											end else begin
												stage_n = STG_DATA;
												nwd     = 1'b1;
											end
										end
										STG_RDEV: begin
											stage_n = STG_DATA;
											go_en   = 1'b1;
											if (bytes_q == '0) begin
												go_to = PH_SPA;
											end else begin
												shift_n = '0;
												bit_n   = BIT_MSB;
												go_to   = PH_RHI;
											end
										end
										default: nwd = 1'b1;
									endcase
								end
							end
							PH_RHI: begin
								shift_n = {shift_q[6:0], item.sda_in};
								go_en   = 1'b1;
								go_to   = PH_RLO;
							end
							PH_RLO: begin
								go_en = 1'b1;
								if (bit_q == '0) begin
									bytes_n = bytes_q - COUNT_W'(1);
									go_to   = PH_MSET;
								end else begin
									bit_n = bit_q - 3'd1;
									go_to = PH_RHI;
								end
							end
							PH_MSET: begin go_en = 1'b1; go_to = PH_MHI; end
							PH_MHI:  begin go_en = 1'b1; go_to = PH_MLO; end
							PH_MLO: begin
								go_en = 1'b1;
								if (bytes_q == '0) begin
									go_to = PH_SPA;
								end else begin
									shift_n = '0;
									bit_n   = BIT_MSB;
									go_to   = PH_RHI;
								end
							end
							PH_SPA: begin go_en = 1'b1; go_to = PH_SPB; end
							PH_SPB: begin go_en = 1'b1; go_to = PH_SPC; end
							default: begin
								phase_n = PH_IDLE;
								tick_n  = '0;
							end
						endcase
					end
				end
			end
			default: ;
		endcase

		// Fetch the next write byte, or park until one is supplied.
		if (nwd) begin
			if (bytes_q == '0) begin
				go_en = 1'b1;
				go_to = PH_SPA;
			end else if (held_vld_q) begin
				held_vld_n = 1'b0;
				bytes_n    = bytes_q - COUNT_W'(1);
				shift_n    = held_q;
				bit_n      = BIT_MSB;
				go_en      = 1'b1;
				go_to      = PH_WSET;
			end else begin
				phase_n = PH_WAIT;
			end
		end

		// Entering a phase restarts its timer and sets the line levels.
		if (go_en) begin
			phase_n = go_to;
			tick_n  = ticks_eff;
			case (go_to)
				PH_STA:  begin scl_n = 1'b1; sda_n = 1'b1; end
				PH_STB:  sda_n = 1'b0;
				PH_STC:  scl_n = 1'b0;
				PH_WSET: sda_n = shift_n[bit_n];
				PH_WHI, PH_RHI, PH_MHI, PH_SPB: scl_n = 1'b1;
				PH_WLO, PH_RLO, PH_MLO: scl_n = 1'b0;
				PH_AHI:  begin scl_n = 1'b1; sda_n = 1'b1; end
				PH_ALO:  begin scl_n = 1'b0; sda_n = 1'b1; end
				PH_MSET: sda_n = (bytes_n == '0);
				PH_SPA:  begin scl_n = 1'b0; sda_n = 1'b0; end
				PH_SPC:  sda_n = 1'b1;
				default: ;
			endcase
		end
	end

	// Result of this beat, seen after its state update.
	always_comb begin
		rvalid = fire && (phase_q == PH_RHI) && (bit_q == '0);
		done   = fire && (phase_q == PH_SPC);
		rel    = (phase_n == PH_AHI) || (phase_n == PH_RHI) || (phase_n == PH_RLO);

		res.scl_level  = scl_n;
		res.sda_level  = rel ? 1'b1 : sda_n;
		res.sda_drive  = !rel;
		res.read_data  = rvalid ? shift_n : 8'h00;
		res.read_valid = rvalid;
		res.need_byte  = (phase_n == PH_WAIT);
		res.busy_res   = (phase_n != PH_IDLE);
		res.done_res   = done;
		res.status     = done ? nack_q : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICK_W'(1);
		end else if (cfg_we) begin
			ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			stage_q    <= STG_DEV;
			bit_q      <= '0;
			bytes_q    <= '0;
			shift_q    <= '0;
			tick_q     <= '0;
			rmode_q    <= 1'b0;
			dev_q      <= '0;
			reg_q      <= '0;
			held_q     <= '0;
			held_vld_q <= 1'b0;
			nack_q     <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
		end else if (step) begin
			phase_q    <= phase_n;
			stage_q    <= stage_n;
			bit_q      <= bit_n;
			bytes_q    <= bytes_n;
			shift_q    <= shift_n;
			tick_q     <= tick_n;
			rmode_q    <= rmode_n;
			dev_q      <= dev_n;
			reg_q      <= reg_n;
			held_q     <= held_n;
			held_vld_q <= held_vld_n;
			nack_q     <= nack_n;
			scl_q      <= scl_n;
			sda_q      <= sda_n;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |-> !res.busy_res)
		else $error("done reported while the transaction stays busy");

	a_read_phase_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RHI || phase_q == PH_RLO || phase_q == PH_MSET) |-> rmode_q)
		else $error("read data phase entered in a write transaction");

	a_rvalid_mode: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.read_valid |-> rmode_q && stage_q == STG_DATA)
		else $error("read byte reported outside the read data bytes");

	a_wait_write: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_WAIT |-> !rmode_q && bytes_q != '0)
		else $error("waiting for a write byte with none owed");

endmodule

/* sv/i2c_master_register_access_unit.sv */
// Top level of the I2C master register access unit: input stage, phase
// sequencer and result register. Depends on i2cm_pkg, i2cm_in_reg, i2cm_core.
//
// Usage: every input beat is one request, its kind in s_axis_tuser: a tick
// (advances the bus timing and samples SDA), a begin (loads a register read
// or write transaction) or a write byte (supplies the next data byte). Each
// input beat yields exactly one output beat with the SCL/SDA levels to drive,
// the SDA drive enable, any received byte and the busy/done/status flags.
// The cfg channel writes the number of ticks per bus half-phase (zero acts
// as one); it is always ready. The user must see that it is written only
// while the unit is idle; the unit itself does not enforce this. A result
// beat is offered on the master side once its input beat has passed the input
// register and reached the result register. Throughput: one beat per clock
// while the receiver keeps taking results; s_axis_tready stays high as long
// as the output register is empty or is being drained.
// Reset puts both lines high, the sequencer idle and half-phase ticks at one.
// When the receiver stalls, the result waits in the output register, one more
// beat waits in the input stage, and s_axis_tready drops until space frees.
module i2c_master_register_access_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [i2cm_pkg::TICK_W-1:0]       cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// is_read[0], slave_addr[8:1], reg_index[16:9], byte_count[32:17],
	// write_data[40:33], sda_in[41], zero[47:42]
	input  logic [i2cm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// req_type[1:0]
	input  logic [i2cm_pkg::IN_USER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// scl_level[0], sda_level[1], sda_drive[2], read_data[10:3],
	// read_valid[11], need_byte[12], busy_res[13], done_res[14], status[15]
	output logic [i2cm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import i2cm_pkg::*;

	item_t in_item;
	item_t item_s1;
	logic  valid_s1;
	logic  take;
	res_t  res;
	res_t  out_q;
	logic  out_valid_q;

	assign cfg_ready = 1'b1;

	assign in_item.req_type   = s_axis_tuser[1:0];
	assign in_item.is_read    = s_axis_tdata[0];
	assign in_item.slave_addr = s_axis_tdata[8:1];
	assign in_item.reg_index  = s_axis_tdata[16:9];
	assign in_item.byte_count = s_axis_tdata[32:17];
	assign in_item.write_data = s_axis_tdata[40:33];
	assign in_item.sda_in     = s_axis_tdata[41];

	// The held beat moves on when the result register is free or draining.
	assign take = valid_s1 && (!out_valid_q || m_axis_tready);

	i2cm_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_valid  (s_axis_tvalid),
		.s_ready  (s_axis_tready),
		.item     (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cm_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.step     (take),
		.item     (item_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.status, out_q.done_res, out_q.busy_res, out_q.need_byte,
		out_q.read_valid, out_q.read_data, out_q.sda_drive, out_q.sda_level,
		out_q.scl_level};

endmodule

/* tb/sv/i2c_master_register_access_unit_test.sv */
// Self-checking testbench for the I2C master register access unit: drives
// request beats, predicts every result beat and compares them field by field.
// Depends on i2cm_pkg and i2c_master_register_access_unit.
module i2c_master_register_access_unit_test;
	import i2cm_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int TXN_BUDGET = 100000;

	// Bus master state as the predictor sees it.
	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bit_idx;
		logic [15:0] left;
		logic [7:0]  shreg;
		logic [15:0] tick_cnt;
		logic        rd;
		logic [7:0]  dev;
		logic [7:0]  regb;
		logic [7:0]  held;
		logic        held_ok;
		logic        nack;
		stage_t      stage;
		logic        scl;
		logic        sda;
		logic [15:0] half_ticks;
	} bus_model_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [TICK_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [IN_USER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	item_t pending_requests[$];
	res_t expected_bus_results[$];
	bus_model_t chk_st;
	bus_model_t gen_st;
	item_t cur_item;
	int gen_count = 0;
	int ack_slot = 0;
	int nack_slot = -1;
	logic ack_level = 1'b0;
	int s_gap = 0;
	int s_quiet = 0;
	int m_gap = 0;
	int m_quiet = 0;
	int mismatches = 0;
	int unsigned cycle_count = 0;

	i2c_master_register_access_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bus_model_t bus_model_reset();
		bus_model_t st;
		st = '0;
		st.phase = PH_IDLE;
		st.stage = STG_DEV;
		st.scl = 1'b1;
		st.sda = 1'b1;
		st.half_ticks = 16'd1;
		return st;
	endfunction

	function automatic void enter_phase(inout bus_model_t st, input phase_t p);
		st.phase = p;
		st.tick_cnt = (st.half_ticks == 16'd0) ? 16'd1 : st.half_ticks;
		case (p)
			PH_STA: begin
				st.scl = 1'b1;
				st.sda = 1'b1;
			end
			PH_STB: st.sda = 1'b0;
			PH_STC: st.scl = 1'b0;
			PH_WSET: st.sda = st.shreg[st.bit_idx];
			PH_WHI, PH_RHI, PH_MHI, PH_SPB: st.scl = 1'b1;
			PH_WLO, PH_RLO, PH_MLO: st.scl = 1'b0;
			PH_AHI: begin
				st.scl = 1'b1;
				st.sda = 1'b1;
			end
			PH_ALO: begin
				st.scl = 1'b0;
				st.sda = 1'b1;
			end
			PH_MSET: st.sda = (st.left == 16'd0);
			PH_SPA: begin
				st.scl = 1'b0;
				st.sda = 1'b0;
			end
			PH_SPC: st.sda = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic void send_byte(inout bus_model_t st, input logic [7:0] b);
		st.shreg = b;
		st.bit_idx = BIT_MSB;
		enter_phase(st, PH_WSET);
	endfunction

	function automatic void start_read_byte(inout bus_model_t st);
		st.shreg = 8'd0;
		st.bit_idx = BIT_MSB;
		enter_phase(st, PH_RHI);
	endfunction

	// Either stop, send the buffered byte, or park until a byte is supplied.
	function automatic void next_write_byte(inout bus_model_t st);
		if (st.left == 16'd0) begin
			enter_phase(st, PH_SPA);
		end else if (st.held_ok) begin
			st.held_ok = 1'b0;
			st.left = st.left - 16'd1;
			send_byte(st, st.held);
		end else begin
			st.phase = PH_WAIT;
		end
	endfunction

	function automatic void after_ack_slot(inout bus_model_t st);
		if (st.rd && st.nack) begin
			enter_phase(st, PH_SPA);
		end else begin
			case (st.stage)
				STG_DEV: begin
					st.stage = STG_REG;
					send_byte(st, st.regb);
				end
				STG_REG: begin
					if (st.rd) begin
						st.stage = STG_RDEV;
						enter_phase(st, PH_STA);
					end else begin
						st.stage = STG_DATA;
						next_write_byte(st);
					end
				end
				STG_RDEV: begin
					st.stage = STG_DATA;
					if (st.left == 16'd0)
						enter_phase(st, PH_SPA);
					else
						start_read_byte(st);
				end
				default: next_write_byte(st);
			endcase
		end
	endfunction

	// Advances the bus master by one request and returns its result beat.
	function automatic res_t i2c_bus_step(inout bus_model_t st, input item_t it);
		res_t r;
		logic rel;
		r = '0;
		case (it.req_type)
			REQ_BEGIN: begin
				if (st.phase == PH_IDLE) begin
					st.rd = it.is_read;
					st.dev = it.slave_addr;
					st.regb = it.reg_index;
					st.left = it.byte_count;
					st.nack = 1'b0;
					st.held_ok = 1'b0;
					st.stage = STG_DEV;
					st.bit_idx = 3'd0;
					st.shreg = 8'd0;
					enter_phase(st, PH_STA);
				end
			end
			REQ_WBYTE: begin
				if (st.phase != PH_IDLE && !st.rd) begin
					st.held = it.write_data;
					st.held_ok = 1'b1;
				end
			end
			REQ_TICK: begin
				if (st.phase == PH_WAIT) begin
					if (st.held_ok)
						next_write_byte(st);
				end else if (st.phase != PH_IDLE) begin
					if (st.tick_cnt > 16'd1) begin
						st.tick_cnt = st.tick_cnt - 16'd1;
					end else begin
						case (st.phase)
							PH_STA: enter_phase(st, PH_STB);
							PH_STB: enter_phase(st, PH_STC);
							PH_STC: send_byte(st, (st.stage == STG_RDEV) ?
								(st.dev | READ_FLAG) : st.dev);
							PH_WSET: enter_phase(st, PH_WHI);
							PH_WHI: enter_phase(st, PH_WLO);
							PH_WLO: begin
								if (st.bit_idx == 3'd0) begin
									enter_phase(st, PH_AHI);
								end else begin
									st.bit_idx = st.bit_idx - 3'd1;
									enter_phase(st, PH_WSET);
								end
							end
							PH_AHI: begin
								if (it.sda_in)
									st.nack = 1'b1;
								enter_phase(st, PH_ALO);
							end
							PH_ALO: after_ack_slot(st);
							PH_RHI: begin
								st.shreg = {st.shreg[6:0], it.sda_in};
								if (st.bit_idx == 3'd0) begin
									r.read_valid = 1'b1;
									r.read_data = st.shreg;
								end
								enter_phase(st, PH_RLO);
							end
							PH_RLO: begin
								if (st.bit_idx == 3'd0) begin
									st.left = st.left - 16'd1;
									enter_phase(st, PH_MSET);
								end else begin
									st.bit_idx = st.bit_idx - 3'd1;
									enter_phase(st, PH_RHI);
								end
							end
							PH_MSET: enter_phase(st, PH_MHI);
							PH_MHI: enter_phase(st, PH_MLO);
							PH_MLO: begin
								if (st.left == 16'd0)
									enter_phase(st, PH_SPA);
								else
									start_read_byte(st);
							end
							PH_SPA: enter_phase(st, PH_SPB);
							PH_SPB: enter_phase(st, PH_SPC);
							default: begin
								r.done_res = 1'b1;
								r.status = st.nack;
								st.phase = PH_IDLE;
								st.tick_cnt = 16'd0;
							end
						endcase
					end
				end
			end
			default: ;
		endcase
		// SDA is released for the slave's ACK bit and for read data bits.
		rel = (st.phase == PH_AHI) || (st.phase == PH_RHI) || (st.phase == PH_RLO);
		r.scl_level = st.scl;
		r.sda_level = rel ? 1'b1 : st.sda;
		r.sda_drive = !rel;
		r.need_byte = (st.phase == PH_WAIT);
		r.busy_res = (st.phase != PH_IDLE);
		return r;
	endfunction

	function automatic res_t unpack_result(input logic [OUT_DATA_W-1:0] d);
		res_t r;
		r.scl_level = d[0];
		r.sda_level = d[1];
		r.sda_drive = d[2];
		r.read_data = d[10:3];
		r.read_valid = d[11];
		r.need_byte = d[12];
		r.busy_res = d[13];
		r.done_res = d[14];
		r.status = d[15];
		return r;
	endfunction

	// Mostly back-to-back, sometimes a short gap, rarely a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic item_t rand_item();
		item_t it;
		it.req_type = REQ_TICK;
		it.is_read = 1'($urandom_range(0, 1));
		it.slave_addr = 8'($urandom);
		it.reg_index = 8'($urandom);
		it.byte_count = 16'($urandom);
		it.write_data = 8'($urandom);
		it.sda_in = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Queues a request and follows it with the generator's own copy of the
	// master so that the slave's ACK level can be planned per slot.
	task automatic push_req(input item_t it);
		phase_t was;
		was = gen_st.phase;
		void'(i2c_bus_step(gen_st, it));
		pending_requests.push_back(it);
		gen_count++;
		if (was != PH_AHI && gen_st.phase == PH_AHI) begin
			ack_level = (ack_slot == nack_slot) || (!gen_st.rd && $urandom_range(0, 99) < 10);
			ack_slot++;
		end
	endtask

	task automatic bus_tick();
		item_t it;
		it = rand_item();
		if (gen_st.phase == PH_AHI)
			it.sda_in = ack_level;
		push_req(it);
	endtask

	task automatic idle_noise(input int n);
		item_t it;
		repeat (n) begin
			it = rand_item();
			case ($urandom_range(0, 2))
				0: it.req_type = REQ_TICK;
				1: it.req_type = REQ_NONE;
				default: it.req_type = REQ_WBYTE;
			endcase
			push_req(it);
		end
	endtask

	// Stray requests during a transfer: unknown kind, begin while busy,
	// or a write byte that arrives early or during a read.
	task automatic busy_noise();
		item_t it;
		it = rand_item();
		case ($urandom_range(0, 2))
			0: it.req_type = REQ_NONE;
			1: it.req_type = REQ_BEGIN;
			default: it.req_type = REQ_WBYTE;
		endcase
		push_req(it);
	endtask

	task automatic run_txn(input logic rd, input logic [7:0] dev, input logic [7:0] regb,
		input logic [15:0] cnt, input int nslot, input int budget);
		item_t it;
		int n;
		it = rand_item();
		it.req_type = REQ_BEGIN;
		it.is_read = rd;
		it.slave_addr = dev;
		it.reg_index = regb;
		it.byte_count = cnt;
		ack_slot = 0;
		ack_level = 1'b0;
		nack_slot = nslot;
		push_req(it);
		n = 0;
		while (gen_st.phase != PH_IDLE && n < budget) begin
			if (gen_st.phase == PH_WAIT && $urandom_range(0, 2) == 0) begin
				it = rand_item();
				it.req_type = REQ_WBYTE;
				push_req(it);
			end else if ($urandom_range(0, 99) < 3) begin
				busy_noise();
			end else begin
				bus_tick();
			end
			n++;
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_axis_tvalid ||
			expected_bus_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_half_ticks(input logic [15:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		chk_st.half_ticks = v;
		gen_st.half_ticks = v;
	endtask

	task automatic random_phase(input logic [15:0] v, input int target);
		int start;
		int kind;
		write_half_ticks(v);
		start = gen_count;
		while (gen_count - start < target) begin
			if ($urandom_range(0, 4) == 0)
				idle_noise($urandom_range(1, 3));
			kind = $urandom_range(0, 9);
			if (kind < 4)
				run_txn(1'b0, 8'($urandom), 8'($urandom), 16'($urandom_range(0, 3)),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : -1, TXN_BUDGET);
			else if (kind < 8)
				run_txn(1'b1, 8'($urandom), 8'($urandom), 16'($urandom_range(0, 2)), -1,
					TXN_BUDGET);
			else
				run_txn(1'b1, 8'($urandom), 8'($urandom), 16'($urandom),
					$urandom_range(0, 2), TXN_BUDGET);
		end
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_bus_results.push_back(i2c_bus_step(chk_st, cur_item));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (s_gap > 0) begin
					s_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					cur_item = pending_requests.pop_front();
					s_axis_tdata <= {6'b0, cur_item.sda_in, cur_item.write_data,
						cur_item.byte_count, cur_item.reg_index, cur_item.slave_addr,
						cur_item.is_read};
					s_axis_tuser <= cur_item.req_type;
					s_axis_tvalid <= 1'b1;
					if (s_quiet > 0) begin
						s_quiet--;
					end else begin
						if ($urandom_range(0, 49) == 0)
							s_quiet = $urandom_range(20, 100);
						s_gap = pick_gap();
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver with its own random back-pressure.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (m_gap > 0) begin
			m_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (m_quiet > 0) begin
				m_quiet--;
			end else begin
				if ($urandom_range(0, 49) == 0)
					m_quiet = $urandom_range(20, 100);
				m_gap = pick_gap();
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = unpack_result(m_axis_tdata);
			if (expected_bus_results.size() == 0) begin
				$error("result beat %h with nothing expected", m_axis_tdata);
				mismatches++;
			end else begin
				want = expected_bus_results.pop_front();
				check_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
				check_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
				check_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
				check_field("read_data", want.read_data, got.read_data);
				check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
				check_field("need_byte", 8'(want.need_byte), 8'(got.need_byte));
				check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(got.done_res));
				check_field("status", 8'(want.status), 8'(got.status));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		chk_st = bus_model_reset();
		gen_st = bus_model_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle requests, then transfers at the field extremes.
		write_half_ticks(16'd1);
		idle_noise(4);
		run_txn(1'b0, 8'h00, 8'hFF, 16'd0, -1, TXN_BUDGET);
		run_txn(1'b1, 8'hFF, 8'h00, 16'd1, -1, TXN_BUDGET);
		// Slave refuses the device address, then the repeated-start address.
		run_txn(1'b1, 8'hA5, 8'h5A, 16'hFFFF, 0, TXN_BUDGET);
		run_txn(1'b1, 8'h5A, 8'hA5, 16'h8000, 2, TXN_BUDGET);
		// Write where the register byte is refused; the transfer goes on.
		run_txn(1'b0, 8'h3C, 8'hC3, 16'd2, 1, TXN_BUDGET);
		idle_noise(3);

		random_phase(16'd2, 40);
		random_phase(16'd0, 50);
		random_phase(16'd1, 50);

		// Widest half-phase: the transfer just starts and stays in its first step.
		write_half_ticks(16'hFFFF);
		idle_noise(3);
		run_txn(1'b0, 8'($urandom), 8'($urandom), 16'($urandom), -1, 50);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
